// ===== hdl/assert_macros.svh =====
// assertion macros shared by the anagram group classifier rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in same-cycle check");

// antecedent implies consequent in the next cycle
`define AGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in next-cycle check");

`endif

// ===== hdl/agc_pkg.sv =====
// shared types for the anagram group classifier
// status codes and controller/datapath command and status groups
package agc_pkg;

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } agc_status_e;

  typedef struct packed {
    logic        take_letter;
    logic        search_start;
    logic        search_step;
    logic        finish;
    logic        store;
    agc_status_e res_code;
  } agc_cmd_t;

  typedef struct packed {
    logic too_long;
    logic match;
    logic exhausted;
    logic table_full;
  } agc_stat_t;

endpackage

// ===== hdl/agc_dpath.sv =====
// datapath: letter counters, signature memory, search pipeline, result register
// depends on agc_pkg for the command and status groups
module agc_dpath #(
  parameter int MAX_GROUPS    = 64,
  parameter int MAX_WORD_LEN  = 63,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [4:0]        letter_code_i,
  input  logic              has_letter_i,
  input  agc_pkg::agc_cmd_t cmd_i,
  output agc_pkg::agc_stat_t stat_o,
  output logic [5:0]        group_index_o,
  output logic [1:0]        status_o
);
  import agc_pkg::*;

  localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);
  localparam int UW    = $clog2(MAX_GROUPS + 1);
  localparam int GI_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam logic [LEN_W-1:0] MaxLen  = LEN_W'(MAX_WORD_LEN);
  localparam logic [UW-1:0]    MaxUsed = UW'(MAX_GROUPS);

  typedef logic [ALPHABET_SIZE-1:0][CNT_W-1:0] sig_t;

  sig_t             cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [UW-1:0]    used_q, used_d;
  logic [UW-1:0]    ptr_q, ptr_d;
  logic [UW-1:0]    cmp_idx_q;
  logic             cmp_vld_q;
  sig_t             rd_q;
  sig_t             mem [MAX_GROUPS];
  logic             letter_ok;
  logic             more_rows;
  logic [5:0]       gidx_q;
  logic [1:0]       gstat_q;
  logic [31:0]      idx_wide;

  assign letter_ok = has_letter_i && (32'(letter_code_i) < 32'(ALPHABET_SIZE));
  assign more_rows = ptr_q < used_q;

  always_comb begin
    cnt_d = cnt_q;
    len_d = len_q;
    if (cmd_i.finish) begin
      cnt_d = '0;
      len_d = '0;
    end else if (cmd_i.take_letter && letter_ok && (len_q <= MaxLen)) begin
      len_d = len_q + LEN_W'(1);
      if (len_q < MaxLen) begin
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
          if (32'(letter_code_i) == 32'(k)) begin
            cnt_d[k] = cnt_q[k] + CNT_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.search_start) begin
      ptr_d = '0;
    end else if (cmd_i.search_step && more_rows) begin
      ptr_d = ptr_q + UW'(1);
    end
  end

  assign used_d = cmd_i.store ? used_q + UW'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      len_q     <= '0;
      used_q    <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      len_q  <= len_d;
      used_q <= used_d;
      ptr_q  <= ptr_d;
      if (cmd_i.search_start) begin
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.search_step) begin
        cmp_vld_q <= more_rows;
      end
    end
  end

  // signature memory, one row per group
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[used_q[GI_W-1:0]] <= cnt_q;
    end
    if (cmd_i.search_step && more_rows) begin
      rd_q      <= mem[ptr_q[GI_W-1:0]];
      cmp_idx_q <= ptr_q;
    end
  end

  always_comb begin
    case (cmd_i.res_code)
      ST_EXISTING: idx_wide = 32'(cmp_idx_q);
      ST_NEW:      idx_wide = 32'(used_q);
      default:     idx_wide = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      gidx_q  <= idx_wide[5:0];
      gstat_q <= cmd_i.res_code;
    end
  end

  assign stat_o.too_long   = len_q > MaxLen;
  assign stat_o.match      = cmp_vld_q && (rd_q == cnt_q);
  assign stat_o.exhausted  = !cmp_vld_q && (ptr_q == used_q);
  assign stat_o.table_full = used_q == MaxUsed;
  assign group_index_o     = gidx_q;
  assign status_o          = gstat_q;

endmodule

// ===== hdl/agc_ctrl.sv =====
// controller: collects letters, sequences the group search, owns the output valid
// depends on agc_pkg for the command and status groups
module agc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               word_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  agc_pkg::agc_stat_t stat_i,
  output agc_pkg::agc_cmd_t  cmd_o
);
  import agc_pkg::*;

  typedef enum logic [1:0] {
    S_COLLECT = 2'b01,
    S_SEARCH  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;
  logic   done;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.res_code     = ST_EXISTING;
    in_ready_o         = 1'b0;
    done               = 1'b0;
    case (state_q)
      S_COLLECT: begin
        in_ready_o        = 1'b1;
        cmd_o.take_letter = in_valid_i;
        if (in_valid_i && word_end_i) begin
          cmd_o.search_start = 1'b1;
          state_d            = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat_i.too_long) begin
          cmd_o.res_code = ST_TOO_LONG;
          done           = 1'b1;
        end else if (stat_i.match) begin
          cmd_o.res_code = ST_EXISTING;
          done           = 1'b1;
        end else if (stat_i.exhausted) begin
          cmd_o.res_code = stat_i.table_full ? ST_FULL : ST_NEW;
          done           = 1'b1;
        end else begin
          cmd_o.search_step = 1'b1;
        end
        if (done && out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.store  = cmd_o.res_code == ST_NEW;
          state_d      = S_COLLECT;
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  assign out_vld_d   = cmd_o.finish ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== hdl/anagram_group_classifier_top.sv =====
// top level of the anagram group classifier
// instantiates agc_ctrl and agc_dpath, uses agc_pkg and assert_macros.svh
`include "assert_macros.svh"

// Words stream in one letter request per cycle while letters are collected;
// each letter is counted into a per-word signature of ALPHABET_SIZE counters.
// A request marked word_end starts a search of the signature memory, which
// reads one stored group row per cycle. After the word end is taken, input
// stays blocked until a row matches, the stored rows are exhausted, or the
// word is found too long, plus any wait for the output register to free up.
// The result sits in an output register, so input continues while it waits
// to be taken. The group table needs no clearing pass: only rows below the
// group count are read.
module anagram_group_classifier_top #(
  parameter int MAX_GROUPS    = 64,
  parameter int MAX_WORD_LEN  = 63,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] letter_code_i,
  input  logic       has_letter_i,
  input  logic       word_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] group_index_o,
  output logic [1:0] status_o
);
  import agc_pkg::*;

  agc_cmd_t  cmd;
  agc_stat_t stat;

  agc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .word_end_i  (word_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  agc_dpath #(
    .MAX_GROUPS    (MAX_GROUPS),
    .MAX_WORD_LEN  (MAX_WORD_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .letter_code_i (letter_code_i),
    .has_letter_i  (has_letter_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .group_index_o (group_index_o),
    .status_o      (status_o)
  );

  `AGC_ASSERT_NEXT(a_end_stops_input, in_valid_i && in_ready_o && word_end_i, !in_ready_o)
  `AGC_ASSERT_NOW(a_no_store_when_full, cmd.store, !stat.table_full)
  `AGC_ASSERT_NOW(a_match_not_exhausted, stat.match, !stat.exhausted)
  `AGC_ASSERT_NEXT(a_finish_loads_out, cmd.finish, out_valid_o)

endmodule
